// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wmpf_pkg.sv
// ----------------------------------------------------------------------------
// wmpf_pkg
// types and constants of the window mean pulse finder
// ----------------------------------------------------------------------------
package wmpf_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int MAX_TICKS_DEF  = 65536;

  localparam int SAMPLE_W     = 16;
  localparam int WIDTH_REG_W  = 7;
  localparam int OFFSET_W     = 16;
  localparam int TICK_OUT_W   = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_RESET  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_WIDTH = 3'd0,
    REG_RISE_LEVEL   = 3'd1,
    REG_FALL_UPPER   = 3'd2,
    REG_FALL_LOWER   = 3'd3,
    REG_TICK_OFFSET  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_t;

  typedef struct packed {
    logic [TICK_OUT_W-1:0] pulse_start;
    logic [TICK_OUT_W-1:0] pulse_end;
  } out_t;

endpackage

// File: rtl/wmpf_prefix_ram.sv
// ----------------------------------------------------------------------------
// wmpf_prefix_ram
// ring of running prefix sums; each write also reads the entry one window back
// ----------------------------------------------------------------------------
module wmpf_prefix_ram #(
  parameter  int DEPTH  = wmpf_pkg::MAX_WINDOW_DEF,
  parameter  int DATA_W = 22,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int WW     = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [WW-1:0]     win_len,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [WW-1:0]     back;
  logic [AW:0]       rd_sum;
  logic [AW:0]       rd_wrap;
  logic [AW-1:0]     rd_addr;

  // address of the entry written win_len transactions ago
  always_comb begin
    back   = WW'(DEPTH) - win_len;
    rd_sum = {1'b0, wr_addr} + (AW+1)'(back);
    if (rd_sum >= (AW+1)'(DEPTH)) begin
      rd_wrap = rd_sum - (AW+1)'(DEPTH);
    end else begin
      rd_wrap = rd_sum;
    end
    rd_addr = rd_wrap[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      rd_data_r    <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/window_mean_pulse_finder.sv
// ----------------------------------------------------------------------------
// window_mean_pulse_finder
// moving window mean with rise level and hysteresis fall band, one pulse
// (start, end) reported per closed or truncated pulse
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall    wmpf_pkg::in_t
//   out_     output     out_valid / out_stall  wmpf_pkg::out_t
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one sample per cycle sustained while in_stall is low; a result is loaded into
// the output register from the middle stage registers and the prefix ring read
// synchronous active-low reset clears control state and restores register
// defaults; the prefix ring needs no clearing
// a held output only stalls the input once the middle stage is also full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module window_mean_pulse_finder #(
  parameter int MAX_WINDOW = wmpf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_TICKS  = wmpf_pkg::MAX_TICKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wmpf_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wmpf_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wmpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wmpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW     = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (WW > wmpf_pkg::WIDTH_REG_W) ? WW : wmpf_pkg::WIDTH_REG_W;
  localparam int SUM_W  = wmpf_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int PW     = wmpf_pkg::SAMPLE_W + WW + 1;
  localparam int TICK_W = $clog2(MAX_TICKS);
  localparam int TW1    = TICK_W + 1;
  localparam int EW     = ((TW1 > wmpf_pkg::OFFSET_W) ? TW1 : wmpf_pkg::OFFSET_W) + 1;

  // configuration
  logic [wmpf_pkg::WIDTH_REG_W-1:0]    width_r;
  logic signed [wmpf_pkg::SAMPLE_W-1:0] rise_r;
  logic signed [wmpf_pkg::SAMPLE_W-1:0] fu_r;
  logic signed [wmpf_pkg::SAMPLE_W-1:0] fl_r;
  logic [wmpf_pkg::OFFSET_W-1:0]       off_r;
  logic                                cfg_acc;
  logic [CMP_W-1:0]                    width_ext;
  logic [CMP_W-1:0]                    width_clip;
  logic [WW-1:0]                       w_eff;

  // front stage
  logic                                in_acc;
  logic [TICK_W-1:0]                   tick_cnt_r;
  logic [AW-1:0]                       pos_r;
  logic [SUM_W-1:0]                    cum_r;
  logic [SUM_W-1:0]                    cum_nxt;
  logic [TW1-1:0]                      tick_p1;
  logic [TW1-1:0]                      idx_full;
  logic [SUM_W-1:0]                    rd_data;

  // middle stage
  logic                                s1_valid_r;
  logic                                s1_adv;
  logic                                s1_last_r;
  logic                                s1_eval_r;
  logic                                s1_first_r;
  logic [SUM_W-1:0]                    s1_cum_r;
  logic [TICK_W-1:0]                   s1_idx_r;
  logic [TICK_W-1:0]                   s1_tick_r;
  logic [TW1-1:0]                      s1_end_r;
  logic signed [PW-1:0]                s1_rise_p_r;
  logic signed [PW-1:0]                s1_fu_p_r;
  logic signed [PW-1:0]                s1_fl_p_r;
  logic signed [PW-1:0]                w_signed;

  // pulse state
  logic                                open_r;
  logic                                open_nxt;
  logic [TICK_W-1:0]                   start_r;
  logic [TICK_W-1:0]                   start_nxt;
  logic                                quiet_r;
  logic                                quiet_nxt;
  logic [TICK_W-1:0]                   recent_r;
  logic [TICK_W-1:0]                   recent_nxt;
  logic [SUM_W-1:0]                    win_sum;
  logic signed [PW-1:0]                sum_ext;
  logic                                above_rise;
  logic                                below_fu;
  logic                                above_fl;
  logic                                emit;
  logic [TW1-1:0]                      em_end;
  logic [EW-1:0]                       em_start_sum;
  logic [EW-1:0]                       em_end_sum;

  // output register
  logic                                out_valid_r;
  wmpf_pkg::out_t                      out_data_r;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= wmpf_pkg::WIDTH_REG_W'(wmpf_pkg::WIDTH_RESET);
      rise_r  <= '0;
      fu_r    <= '0;
      fl_r    <= '0;
      off_r   <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        wmpf_pkg::REG_WINDOW_WIDTH: width_r <= cfg_data[wmpf_pkg::WIDTH_REG_W-1:0];
        wmpf_pkg::REG_RISE_LEVEL:   rise_r  <= $signed(cfg_data);
        wmpf_pkg::REG_FALL_UPPER:   fu_r    <= $signed(cfg_data);
        wmpf_pkg::REG_FALL_LOWER:   fl_r    <= $signed(cfg_data);
        wmpf_pkg::REG_TICK_OFFSET:  off_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clips to the ring depth
  always_comb begin
    width_ext = CMP_W'(width_r);
    priority if (width_ext == '0) begin
      width_clip = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_WINDOW)) begin
      width_clip = CMP_W'(MAX_WINDOW);
    end else begin
      width_clip = width_ext;
    end
    w_eff = width_clip[WW-1:0];
  end

  // ---------------------------------------------------------------- handshake
  assign s1_adv   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------- front stage
  assign cum_nxt  = cum_r + SUM_W'($signed(in_data.sample));
  assign tick_p1  = {1'b0, tick_cnt_r} + TW1'(1);
  assign idx_full = tick_p1 - TW1'(w_eff);
  assign w_signed = PW'($signed({1'b0, w_eff}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r <= '0;
      pos_r      <= '0;
      cum_r      <= '0;
    end else if (in_acc) begin
      if (in_data.last_sample) begin
        tick_cnt_r <= '0;
        pos_r      <= '0;
        cum_r      <= '0;
      end else begin
        cum_r <= cum_nxt;
        if (pos_r == AW'(MAX_WINDOW - 1)) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + AW'(1);
        end
        if (tick_cnt_r != TICK_W'(MAX_TICKS - 1)) begin
          tick_cnt_r <= tick_cnt_r + TICK_W'(1);
        end
      end
    end
  end

  wmpf_prefix_ram #(
    .DEPTH  (MAX_WINDOW),
    .DATA_W (SUM_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (in_acc && !in_data.last_sample),
    .wr_addr (pos_r),
    .wr_data (cum_nxt),
    .win_len (w_eff),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r   <= in_data.last_sample;
      s1_eval_r   <= tick_p1 >= TW1'(w_eff);
      s1_first_r  <= tick_p1 == TW1'(w_eff);
      s1_cum_r    <= cum_nxt;
      s1_idx_r    <= idx_full[TICK_W-1:0];
      s1_tick_r   <= tick_cnt_r;
      s1_end_r    <= tick_p1;
      s1_rise_p_r <= PW'(rise_r) * w_signed;
      s1_fu_p_r   <= PW'(fu_r) * w_signed;
      s1_fl_p_r   <= PW'(fl_r) * w_signed;
    end
  end

  // ---------------------------------------------------------------- pulse logic
  assign win_sum    = s1_first_r ? s1_cum_r : s1_cum_r - rd_data;
  assign sum_ext    = PW'($signed(win_sum));
  assign above_rise = sum_ext > s1_rise_p_r;
  assign below_fu   = sum_ext < s1_fu_p_r;
  assign above_fl   = sum_ext > s1_fl_p_r;

  always_comb begin
    open_nxt   = open_r;
    start_nxt  = start_r;
    quiet_nxt  = quiet_r;
    recent_nxt = recent_r;
    emit       = 1'b0;
    em_end     = {1'b0, s1_tick_r};
    if (s1_last_r) begin
      emit       = open_r;
      open_nxt   = 1'b0;
      start_nxt  = '0;
      quiet_nxt  = 1'b0;
      recent_nxt = '0;
    end else if (s1_eval_r) begin
      if (!open_r && above_rise) begin
        open_nxt = 1'b1;
        if (quiet_r) begin
          start_nxt = recent_r;
        end
      end else if (open_r && below_fu && above_fl) begin
        open_nxt = 1'b0;
        emit     = 1'b1;
        em_end   = s1_end_r;
      end
      if (below_fu) begin
        quiet_nxt  = 1'b1;
        recent_nxt = s1_idx_r;
      end
    end
  end

  assign em_start_sum = EW'(start_r) + EW'(off_r);
  assign em_end_sum   = EW'(em_end) + EW'(off_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      start_r  <= '0;
      quiet_r  <= 1'b0;
      recent_r <= '0;
    end else if (s1_adv) begin
      open_r   <= open_nxt;
      start_r  <= start_nxt;
      quiet_r  <= quiet_nxt;
      recent_r <= recent_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_data_r.pulse_start <= em_start_sum[wmpf_pkg::TICK_OUT_W-1:0];
      out_data_r.pulse_end   <= em_end_sum[wmpf_pkg::TICK_OUT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- checks
  `ASSERT_IMPLIES(a_stall_when_full, in_stall, s1_valid_r && out_valid_r, "stall with room")
  `ASSERT_IMPLIES(a_emit_from_open, s1_adv && emit, open_r, "pulse reported while none open")
  `ASSERT_NEXT(a_last_front, in_acc && in_data.last_sample, ~|{tick_cnt_r, pos_r, cum_r}, "front kept")
  `ASSERT_NEXT(a_last_clears_pulse, s1_adv && s1_last_r, !open_r && !quiet_r, "pulse state kept")
  `ASSERT_NEXT(a_middle_holds, s1_valid_r && !s1_adv, s1_valid_r, "held transaction dropped")

endmodule

// File: bench/pulse_tracker.sv
// ----------------------------------------------------------------------------
// pulse_tracker
// watches the sample, result and register channels of the window mean pulse
// finder, predicts every reported pulse from its own copy of the window,
// pulse and register state, and compares each result field by field
// ----------------------------------------------------------------------------
module pulse_tracker
  import wmpf_pkg::*;
#(
  parameter int MAX_WINDOW = wmpf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_TICKS  = wmpf_pkg::MAX_TICKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_t                  out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  logic [WIDTH_REG_W-1:0]    width_reg;
  logic signed [SAMPLE_W-1:0] level_rise;
  logic signed [SAMPLE_W-1:0] level_fall_hi;
  logic signed [SAMPLE_W-1:0] level_fall_lo;
  logic [OFFSET_W-1:0]       start_offset;

  logic signed [SAMPLE_W-1:0] held_samples [MAX_WINDOW];
  int                         write_slot;
  int                         tick_idx;
  bit                         in_pulse;
  int                         pulse_begin;
  int                         quiet_idx;
  bit                         quiet_valid;

  out_t expected_pulses [$];
  out_t oldest;

  task automatic report_mismatch(string what, int got, int want);
    if (fail_count < 40)
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  task automatic queue_pulse(out_t p);
    expected_pulses = {expected_pulses, p};
  endtask

  task automatic clear_waveform();
    write_slot  = 0;
    tick_idx    = 0;
    in_pulse    = 1'b0;
    pulse_begin = 0;
    quiet_idx   = 0;
    quiet_valid = 1'b0;
  endtask

  function automatic out_t make_pulse(int first_tick, int last_tick);
    out_t r;
    r.pulse_start = TICK_OUT_W'(first_tick + int'(start_offset));
    r.pulse_end   = TICK_OUT_W'(last_tick + int'(start_offset));
    return r;
  endfunction

  task automatic track_sample(in_t item);
    int     w;
    int     first;
    int     k;
    longint total;
    bit     rise_hit;
    bit     under_hi;
    bit     over_lo;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WINDOW) ? MAX_WINDOW : int'(width_reg));
    if (item.last_sample) begin
      if (in_pulse) queue_pulse(make_pulse(pulse_begin, tick_idx));
      clear_waveform();
      return;
    end
    held_samples[write_slot] = item.sample;
    if (tick_idx + 1 >= w) begin
      first = tick_idx + 1 - w;
      total = 0;
      for (k = 0; k < w; k++)
        total += held_samples[(write_slot + MAX_WINDOW - k) % MAX_WINDOW];
      rise_hit = total > longint'(level_rise) * w;
      under_hi = total < longint'(level_fall_hi) * w;
      over_lo  = total > longint'(level_fall_lo) * w;
      if (!in_pulse && rise_hit) begin
        in_pulse = 1'b1;
        if (quiet_valid) pulse_begin = quiet_idx;
      end else if (in_pulse && under_hi && over_lo) begin
        in_pulse = 1'b0;
        queue_pulse(make_pulse(pulse_begin, first + w));
      end
      if (under_hi) begin
        quiet_valid = 1'b1;
        quiet_idx   = first;
      end
    end
    write_slot = (write_slot + 1) % MAX_WINDOW;
    if (tick_idx < MAX_TICKS - 1) tick_idx++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg     = WIDTH_REG_W'(WIDTH_RESET);
      level_rise    = '0;
      level_fall_hi = '0;
      level_fall_lo = '0;
      start_offset  = '0;
      fail_count    = 0;
      clear_waveform();
      expected_pulses.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_WIDTH: width_reg     = cfg_data[WIDTH_REG_W-1:0];
          REG_RISE_LEVEL:   level_rise    = cfg_data;
          REG_FALL_UPPER:   level_fall_hi = cfg_data;
          REG_FALL_LOWER:   level_fall_lo = cfg_data;
          REG_TICK_OFFSET:  start_offset  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pulses.size() == 0) begin
          report_mismatch("pulse with none pending, start", out_data.pulse_start, 0);
        end else begin
          oldest = expected_pulses.pop_front();
          if (out_data.pulse_start != oldest.pulse_start)
            report_mismatch("pulse_start", out_data.pulse_start, oldest.pulse_start);
          if (out_data.pulse_end != oldest.pulse_end)
            report_mismatch("pulse_end", out_data.pulse_end, oldest.pulse_end);
        end
      end
      if (in_valid && !in_stall) track_sample(in_data);
    end
    pending <= expected_pulses.size();
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives the window mean pulse finder with directed edge cases, then with
// random waveforms shaped as baseline and pulse segments under many register
// settings and idle patterns, and gives the verdict from the pulse tracker
// ----------------------------------------------------------------------------
module tb_top;
  import wmpf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;
  localparam int                   ITEMS_PER_PHASE = 417;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  int send_idle_pct;
  int recv_stall_pct;
  int cur_base;
  int cur_rise;
  int cur_eff;
  int cur_noise;
  int phase;
  int phase_items;
  int wave_len;
  int cut;

  window_mean_pulse_finder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pulse_tracker u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic send(int s, bit is_last);
    in_t item;
    item.sample      = clamp16(s);
    item.last_sample = is_last;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain all pending pulses, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int eff_width(int w);
    return (w == 0) ? 1 : ((w > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : w);
  endfunction

  task automatic apply_config(int w, int rise, int fu, int fl, int off);
    settle();
    write_reg(REG_WINDOW_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_RISE_LEVEL, clamp16(rise));
    write_reg(REG_FALL_UPPER, clamp16(fu));
    write_reg(REG_FALL_LOWER, clamp16(fl));
    write_reg(REG_TICK_OFFSET, CFG_DATA_W'(off));
    cfg_done();
    cur_eff  = eff_width(w);
    cur_rise = rise;
  endtask

  task automatic random_config();
    int w;
    int b;
    int r;
    int fu;
    int fl;
    int off;
    case ($urandom_range(0, 9))
      0: w = $urandom_range(0, 127);
      1: w = MAX_WINDOW_DEF;
      default: w = $urandom_range(1, 12);
    endcase
    b  = $urandom_range(0, 8000) - 4000;
    r  = b + $urandom_range(40, 1500);
    fu = b + $urandom_range(0, r - b);
    fl = b - $urandom_range(0, 1500);
    case ($urandom_range(0, 11))
      0: begin
        r  = $urandom_range(0, 65535) - 32768;
        fu = $urandom_range(0, 65535) - 32768;
        fl = $urandom_range(0, 65535) - 32768;
      end
      1: r = 32767;
      2: begin
        r  = -32768;
        fu = 32767;
        fl = -32768;
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: off = 0;
      3: off = 65535;
      default: off = $urandom_range(0, 65535);
    endcase
    apply_config(w, r, fu, fl, off);
    cur_base  = b;
    cur_noise = $urandom_range(0, 300);
  endtask

  // baseline and pulse segments, some wild samples, ends on a last-sample transaction
  task automatic gen_waveform(int len, int cut_at);
    int k;
    int seg_left;
    int tgt;
    int s;
    int nw;
    seg_left = 0;
    tgt      = cur_base;
    for (k = 0; k < len; k++) begin
      if (k == cut_at) begin
        settle();
        nw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
        write_reg(REG_WINDOW_WIDTH, CFG_DATA_W'(nw));
        cfg_done();
        cur_eff = eff_width(nw);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 3 * cur_eff + 4);
        tgt = ($urandom_range(0, 99) < 45) ? cur_rise + $urandom_range(1, 1200) : cur_base;
      end
      seg_left--;
      s = tgt + $urandom_range(0, 2 * cur_noise) - cur_noise;
      if ($urandom_range(0, 99) < 8) s = $urandom_range(0, 65535) - 32768;
      send(s, k == len - 1);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_base       = 0;
    cur_rise       = 0;
    cur_eff        = WIDTH_RESET;
    cur_noise      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, open and close, truncated pulse, empty waveform
    apply_config(2, 160, 80, -80, 0);
    send(-32768, 0);
    send(-32768, 0);
    send(32767, 0);
    send(32767, 0);
    send(0, 0);
    send(0, 0);
    send(200, 0);
    send(200, 0);
    send(500, 1);
    send(0, 1);
    // zero width acts as one, top offset
    apply_config(0, 160, 80, -80, 65535);
    send(1000, 0);
    send(0, 0);
    send(1000, 0);
    send(-1, 1);
    // oversized width acts as the maximum, rise level at its floor
    apply_config(127, -32768, 32767, -32768, 12345);
    send(5, 0);
    send(-5, 0);
    send(32767, 1);
    settle();
    write_reg(UNUSED_REG_IDX, 16'hffff);
    cfg_done();
    send(7, 0);
    send(7, 1);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 35;
          recv_stall_pct = 49;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 35;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        random_config();
        repeat ($urandom_range(1, 4)) begin
          wave_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300)
                                                : $urandom_range(1, 3 * cur_eff + 24);
          cut = ($urandom_range(0, 4) == 0 && wave_len > 2) ? $urandom_range(1, wave_len - 1)
                                                            : -1;
          gen_waveform(wave_len, cut);
          phase_items += wave_len;
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/wmpf_pkg.sv
rtl/wmpf_prefix_ram.sv
rtl/window_mean_pulse_finder.sv
bench/pulse_tracker.sv
bench/tb_top.sv
